### rtl/bia_pkg.sv
`timescale 1ns / 1ps

package bia_pkg;

  // Bitmap geometry: the free set is held as ROWS words of WORD_W bits.
  localparam int MAX_BLOCKS = 1024;
  localparam int WORD_W     = 32;
  localparam int ROWS       = MAX_BLOCKS / WORD_W;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int BIT_W      = $clog2(WORD_W);

  // Field widths fixed by the request and response formats.
  localparam int IDX_W = 10;
  localparam int CAP_W = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_BLOCKS = 2'd1,
    ST_UNTRACKED     = 2'd2,
    ST_DOUBLE_FREE   = 2'd3
  } status_t;

endpackage

### rtl/bia_if.sv
`timescale 1ns / 1ps

// Request channel: one allocate or free request.
interface bia_req_if;
  import bia_pkg::*;

  logic             valid;
  logic             ready;
  func_t            func;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, output func, output block_index, input ready);
  modport sink   (input valid, input func, input block_index, output ready);
endinterface

// Response channel: one result per request.
interface bia_rsp_if;
  import bia_pkg::*;

  logic             valid;
  logic             ready;
  status_t          status;
  logic [IDX_W-1:0] granted_index;

  modport source (output valid, output status, output granted_index, input ready);
  modport sink   (input valid, input status, input granted_index, output ready);
endinterface

// Configuration channel: writes the capacity register.
interface bia_cfg_if;
  import bia_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/block_index_allocator.sv
`timescale 1ns / 1ps
// A request's response is registered out of the execute state that follows its acceptance.
// A new request waits until the last has left the execute state: a bitmap word is read
// from the single-port memory at acceptance, then modified and written back in execute.
// Reset (rst_n, synchronous, active low) clears the row summary, the bump pointer and all
// control state and loads capacity 1024; the bitmap memory itself needs no clearing pass.
module block_index_allocator (
  input  logic      clk,
  input  logic      rst_n,
  bia_req_if.sink   in_req,
  bia_rsp_if.source out_rsp,
  bia_cfg_if.sink   cfg_wr
);
  import bia_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // The freed-index set lives in a memory of WORD_W-bit rows. The summary register holds
  // one bit per row that is set exactly when the row has any freed index in it. A row whose
  // summary bit is clear reads as all zero, so reset never has to sweep the memory.
  logic [WORD_W-1:0] bitmap_mem [ROWS];

  logic [ROWS-1:0]   summary_r, summary_nxt;
  logic [CAP_W-1:0]  capacity_r;
  logic [CAP_W-1:0]  bump_r, bump_nxt;
  state_t            state_r, state_nxt;

  // Per-request context captured at acceptance.
  func_t             func_r;
  logic [IDX_W-1:0]  idx_r;
  logic [ROW_W-1:0]  row_r;
  logic              row_vld_r;
  logic              hit_r;
  logic [WORD_W-1:0] rd_data_r;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;

  logic              accept;
  logic [ROW_W-1:0]  rd_row;
  logic [CAP_W-1:0]  cap_eff;
  logic [WORD_W-1:0] word;
  logic [BIT_W-1:0]  top_bit;
  logic [BIT_W-1:0]  idx_bit;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en;

  function automatic logic [ROW_W-1:0] top_row(input logic [ROWS-1:0] v);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (v[i]) r = ROW_W'(i);
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] top_set_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // A new request is taken only when the core is idle and the response register is free
  // or being drained at the same edge, so a result never overwrites an unread one.
  assign in_req.ready = (state_r == S_IDLE) && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_req.ready;

  // The user must write capacity only while idle; the block itself does not enforce it, and the port is always willing.
  assign cfg_wr.ready = 1'b1;

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.granted_index = out_index_r;

  // Capacity above the bitmap size behaves as the bitmap size.
  assign cap_eff = (capacity_r > CAP_W'(MAX_BLOCKS)) ? CAP_W'(MAX_BLOCKS) : capacity_r;

  // Allocate looks at the highest non-empty row; free looks at the row of its index.
  assign rd_row = (in_req.func == FN_ALLOC) ? top_row(summary_r)
                                            : in_req.block_index[BIT_W +: ROW_W];

  assign word    = row_vld_r ? rd_data_r : '0;
  assign top_bit = top_set_bit(word);
  assign idx_bit = idx_r[BIT_W-1:0];

  // Execute stage: decide the result and the bitmap update from the word read last cycle.
  always_comb begin
    state_nxt      = state_r;
    summary_nxt    = summary_r;
    bump_nxt       = bump_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    wr_en          = 1'b0;
    wr_data        = word;

    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_index_nxt  = '0;
        if (func_r == FN_ALLOC) begin
          if (hit_r) begin
            // Take the highest freed index and drop it from the set.
            wr_data              = word & ~(WORD_W'(1) << top_bit);
            wr_en                = 1'b1;
            summary_nxt[row_r]   = |wr_data;
            out_index_nxt        = IDX_W'({row_r, top_bit});
          end else if (bump_r < cap_eff) begin
            out_index_nxt = IDX_W'(bump_r);
            bump_nxt      = bump_r + CAP_W'(1);
          end else begin
            out_status_nxt = ST_OUT_OF_BLOCKS;
          end
        end else begin
          if ({1'b0, idx_r} >= cap_eff) begin
            out_status_nxt = ST_UNTRACKED;
          end else if (word[idx_bit]) begin
            out_status_nxt = ST_DOUBLE_FREE;
          end else begin
            wr_data            = word | (WORD_W'(1) << idx_bit);
            wr_en              = 1'b1;
            summary_nxt[row_r] = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Bitmap memory: one registered read at acceptance, one write-back in the execute cycle.
  // Requests never overlap, so the write always lands before the next read.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= bitmap_mem[rd_row];
    end
    if (wr_en) begin
      bitmap_mem[row_r] <= wr_data;
    end
  end

  // Request context; payload registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= in_req.func;
      idx_r     <= in_req.block_index;
      row_r     <= rd_row;
      row_vld_r <= summary_r[rd_row];
      hit_r     <= |summary_r;
    end
  end

  // State, bookkeeping and the registered response.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      summary_r    <= '0;
      bump_r       <= '0;
      capacity_r   <= CAP_RESET;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
      out_index_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      summary_r    <= summary_nxt;
      bump_r       <= bump_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_index_r  <= out_index_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        capacity_r <= cfg_wr.data;
      end
    end
  end

endmodule

### tb/sv/tb_block_index_allocator.sv
`timescale 1ns / 1ps

module tb_block_index_allocator;
  import bia_pkg::*;

  // A stretch this long with no request, response or register write taken
  // means the block has hung.
  localparam int HANG_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 190;
  localparam int PHASES      = 8;

  // One allocate or free request as the driver presents it.
  typedef struct packed {
    func_t            func;
    logic [IDX_W-1:0] block_index;
  } block_request_t;

  // The response that a request must produce.
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] granted_index;
  } block_grant_t;

  // Everything the allocator remembers: the set of freed indices, the bump
  // pointer of indices never issued, and the capacity register.
  typedef struct packed {
    logic [MAX_BLOCKS-1:0] free_map;
    logic [CAP_W-1:0]      bump_next;
    logic [CAP_W-1:0]      capacity;
  } pool_state_t;

  logic clk;
  logic rst_n;

  bia_req_if req_ch();
  bia_rsp_if rsp_ch();
  bia_cfg_if cfg_ch();

  block_index_allocator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  // pool_model follows the requests the block has accepted and predicts each
  // response. pool_plan runs ahead on the requests as they are queued, so that
  // the stimulus knows which indices are held and can free them.
  pool_state_t    pool_model;
  pool_state_t    pool_plan;
  block_request_t pending_requests[$];
  block_grant_t   expected_grants[$];
  int             held_blocks[$];

  int   requests_queued;
  int   requests_taken;
  int   fault_count;
  int   idle_cycles;
  int   send_gap;
  int   stall_left;
  bit   req_taken;
  bit   calm;
  bit   have_freed;
  logic [IDX_W-1:0] last_freed;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one request to an allocator state. An allocate takes the highest
  // freed index first, even one that a lowered capacity no longer covers, and
  // only then falls back on the bump pointer. The bump pointer stops at the
  // capacity, so a later, larger capacity resumes where it stopped. A capacity
  // above the bitmap size acts as the bitmap size.
  function automatic void serve_request(inout pool_state_t st, input func_t fn,
                                        input logic [IDX_W-1:0] idx,
                                        output status_t status,
                                        output logic [IDX_W-1:0] granted);
    int  limit;
    bit  found;
    limit   = (st.capacity > MAX_BLOCKS) ? MAX_BLOCKS : int'(st.capacity);
    status  = ST_OK;
    granted = '0;
    found   = 1'b0;
    if (fn == FN_ALLOC) begin
      for (int i = MAX_BLOCKS - 1; i >= 0 && !found; i--) begin
        if (st.free_map[i]) begin
          st.free_map[i] = 1'b0;
          granted        = IDX_W'(i);
          found          = 1'b1;
        end
      end
      if (!found) begin
        if (st.bump_next < limit) begin
          granted      = st.bump_next[IDX_W-1:0];
          st.bump_next = st.bump_next + 1'b1;
        end else begin
          status = ST_OUT_OF_BLOCKS;
        end
      end
    end else begin
      // The capacity check comes before the membership check.
      if (idx >= limit) begin
        status = ST_UNTRACKED;
      end else if (st.free_map[idx]) begin
        status = ST_DOUBLE_FREE;
      end else begin
        st.free_map[idx] = 1'b1;
      end
    end
  endfunction

  // Queues a request and keeps the list of held indices up to date.
  task automatic queue_request(input func_t fn, input logic [IDX_W-1:0] idx);
    block_request_t   item;
    status_t          status;
    logic [IDX_W-1:0] granted;
    item.func        = fn;
    item.block_index = idx;
    serve_request(pool_plan, fn, idx, status, granted);
    if (status == ST_OK) begin
      if (fn == FN_ALLOC) begin
        held_blocks.push_back(int'(granted));
      end else begin
        for (int i = 0; i < held_blocks.size(); i++) begin
          if (held_blocks[i] == int'(idx)) begin
            held_blocks.delete(i);
            break;
          end
        end
        last_freed = idx;
        have_freed = 1'b1;
      end
    end
    pending_requests.push_back(item);
    requests_queued++;
  endtask

  // Waits until every queued request has been taken and answered, and then
  // waits on so that the block is certainly back at rest.
  task automatic settle_requests();
    while (requests_taken != requests_queued || expected_grants.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Writes the capacity register while the block is at rest.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    settle_requests();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do begin
      @(posedge clk);
    end while (!(cfg_ch.valid && cfg_ch.ready));
    pool_plan.capacity = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: allocations, and frees of indices that are
  // actually held. The rest repeats the last free to provoke a double free,
  // allocates, or frees an arbitrary index as noise.
  task automatic random_requests(input int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_request(FN_ALLOC, '0);
      end else if (pick < 80 && held_blocks.size() > 0) begin
        queue_request(FN_FREE,
                      IDX_W'(held_blocks[$urandom_range(0, held_blocks.size() - 1)]));
      end else if (pick < 88 && have_freed) begin
        queue_request(FN_FREE, last_freed);
      end else if (pick < 80) begin
        queue_request(FN_ALLOC, IDX_W'($urandom_range(0, 1023)));
      end else begin
        queue_request(FN_FREE, IDX_W'($urandom_range(0, 1023)));
      end
    end
  endtask

  // Request driver. A new request goes out at the falling edge after the
  // previous one was taken, sometimes after a short random gap.
  always @(negedge clk) begin : drive_requests
    block_request_t item;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        item = pending_requests.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.func        <= item.func;
        req_ch.block_index <= item.block_index;
        if (!calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 6);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response back-pressure: ready drops in random bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Monitor: predicts at every accepted request, checks every accepted
  // response against the oldest prediction, tracks register writes, and
  // watches for a hang.
  always @(posedge clk) begin : watch_channels
    block_grant_t     want;
    status_t          status;
    logic [IDX_W-1:0] granted;
    bit               busy;
    busy = 1'b0;
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        busy = 1'b1;
        if (expected_grants.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("unexpected response: status %0d index %0d",
                     rsp_ch.status, rsp_ch.granted_index);
          end
        end else begin
          want = expected_grants.pop_front();
          if (rsp_ch.status !== want.status ||
              rsp_ch.granted_index !== want.granted_index) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("response mismatch: status %0d (want %0d) index %0d (want %0d)",
                       rsp_ch.status, want.status, rsp_ch.granted_index,
                       want.granted_index);
            end
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        busy = 1'b1;
        serve_request(pool_model, req_ch.func, req_ch.block_index, status, granted);
        want.status        = status;
        want.granted_index = granted;
        expected_grants.push_back(want);
        requests_taken++;
        req_taken = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        busy = 1'b1;
        pool_model.capacity = cfg_ch.data;
      end
    end
    idle_cycles = busy ? 0 : idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.func        = FN_ALLOC;
    req_ch.block_index = '0;
    rsp_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    pool_model         = '{free_map: '0, bump_next: '0, capacity: CAP_RESET};
    pool_plan          = pool_model;
    requests_queued    = 0;
    requests_taken     = 0;
    fault_count        = 0;
    idle_cycles        = 0;
    send_gap           = 0;
    stall_left         = 0;
    req_taken          = 1'b0;
    calm               = 1'b0;
    have_freed         = 1'b0;
    last_freed         = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset capacity. Freeing an index that was never
    // issued is legal, a second free of it is a double free, and the next
    // allocate hands the highest freed index back before the bump pointer.
    queue_request(FN_FREE, 10'd1023);
    queue_request(FN_FREE, 10'd1023);
    queue_request(FN_ALLOC, 10'd0);
    queue_request(FN_ALLOC, 10'd1023);
    queue_request(FN_ALLOC, 10'd0);
    queue_request(FN_FREE, 10'd0);
    queue_request(FN_FREE, 10'd1);
    queue_request(FN_ALLOC, 10'd0);
    queue_request(FN_ALLOC, 10'd0);
    queue_request(FN_ALLOC, 10'd0);

    // Capacity zero: every allocate runs dry and every free is untracked.
    write_capacity(11'd0);
    queue_request(FN_ALLOC, 10'd0);
    queue_request(FN_FREE, 10'd0);
    queue_request(FN_FREE, 10'd1023);

    // The bump pointer stopped at three, so raising the capacity to four
    // yields exactly one more index.
    write_capacity(11'd4);
    queue_request(FN_ALLOC, 10'd0);
    queue_request(FN_ALLOC, 10'd0);
    queue_request(FN_FREE, 10'd2);

    // Lowering the capacity leaves index two in the freed set: a free of it
    // is now untracked, yet an allocate still grants it.
    write_capacity(11'd1);
    queue_request(FN_FREE, 10'd2);
    queue_request(FN_ALLOC, 10'd0);
    queue_request(FN_ALLOC, 10'd0);

    // The largest register value acts as the full bitmap size.
    write_capacity(11'd2047);
    queue_request(FN_FREE, 10'd1000);
    queue_request(FN_ALLOC, 10'd0);
    queue_request(FN_ALLOC, 10'd0);

    // Random part, one capacity per phase. The last phase runs at the full
    // size with no gaps or stalls on either side.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_capacity(11'd64);
        1: write_capacity(11'd0);
        2: write_capacity(11'd9);
        3: write_capacity(11'd2047);
        4: write_capacity(11'd300);
        5: write_capacity(CAP_W'($urandom_range(1, 1024)));
        6: write_capacity(11'd1025);
        default: begin
          write_capacity(11'd1024);
          calm = 1'b1;
        end
      endcase
      random_requests(PHASE_ITEMS);
    end

    settle_requests();
    repeat (10) @(posedge clk);
    fault_count += expected_grants.size();
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
